// File: rtl/core/mhg_pkg.sv
// Shared types, constants and helpers of the multiresolution hash-grid encoder.
// No dependencies; used by every module in rtl/core.
package mhg_pkg;

    localparam int MAX_LEVELS_DEF    = 8;
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int FEATURES_DEF      = 2;

    localparam int ADDR_W = 16;   // feature store word address
    localparam int SIZE_W = 17;   // table size, up to 65536
    localparam int CRD_W  = 17;   // Q0.16 coordinate / weight with exact one
    localparam int CELL_W = 15;
    localparam int RES_W  = 16;
    localparam int ACC_W  = 53;

    localparam logic [31:0] HASH_KX = 32'h8da6b343;
    localparam logic [31:0] HASH_KY = 32'hd8163841;
    localparam logic [31:0] HASH_KZ = 32'hcb1ab31f;
    localparam logic [31:0] HASH_KL = 32'h1234567f;
    localparam logic [31:0] HASH_M1 = 32'h85ebca6b;
    localparam logic [31:0] HASH_M2 = 32'hc2b2ae35;

    localparam logic [CRD_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [1:0] REG_BASE_RES = 2'd0;
    localparam logic [1:0] REG_LEVELS   = 2'd1;
    localparam logic [1:0] REG_TBL_LOG2 = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_ENCODE = 1'b1;

    // one corner read in flight
    typedef struct packed {
        logic       vld;
        logic [2:0] corner;
        logic       feat;
    } tag_t;

    // per-level geometry, held stable while a level is processed
    typedef struct packed {
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic [CELL_W-1:0] cz;
        logic [CRD_W-1:0]  wx;
        logic [CRD_W-1:0]  wy;
        logic [CRD_W-1:0]  wz;
        logic [RES_W-1:0]  res;
        logic              direct;
        logic [15:0]       mask;
        logic [19:0]       lvbase;
    } lvl_t;

    // round half up from Q16.32 to Q16.16, saturate to 32 bits
    function automatic logic [31:0] round_sat(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-17:0] r;
        begin
            b = s + ACC_W'(32768);
            r = b[ACC_W-1:16];
            if (r > $signed((ACC_W-16)'(64'h7fffffff)))
                round_sat = 32'h7fffffff;
            else if (r < -$signed((ACC_W-16)'(64'h80000000)))
                round_sat = 32'h80000000;
            else
                round_sat = r[31:0];
        end
    endfunction

endpackage

// File: rtl/core/mhg_level.sv
// Per-level setup pipeline: resolution, cell/weight split per axis, direct check.
// Depends on mhg_pkg. Three register stages, free running.
module mhg_level
(
    input  logic                        clk,
    input  logic [8:0]                  base,
    input  logic [2:0]                  lv,
    input  logic [mhg_pkg::SIZE_W-1:0]  size,
    input  logic [mhg_pkg::CRD_W-1:0]   px,
    input  logic [mhg_pkg::CRD_W-1:0]   py,
    input  logic [mhg_pkg::CRD_W-1:0]   pz,
    output mhg_pkg::lvl_t               lvl
);
    import mhg_pkg::*;

    logic [RES_W-1:0]  res_reg, res1_reg;
    logic [19:0]       lvbase_reg, lvbase1_reg;
    logic [15:0]       mask_reg, mask1_reg;
    logic [SIZE_W-1:0] size0_reg, size1_reg;
    logic [CRD_W-1:0]  px_reg, py_reg, pz_reg;
    logic [31:0]       sx_reg, sy_reg, sz_reg;
    logic [11:0]       res2_reg;
    logic              small_reg, small1_reg;
    lvl_t              lvl_reg, lvl_next;

    // stage 0: resolution, table base and mask of this level
    always_ff @(posedge clk)
    begin
        res_reg    <= RES_W'({7'd0, base} << lv);
        lvbase_reg <= 20'(20'(lv) * 20'(size));
        mask_reg   <= 16'(size - SIZE_W'(1));
        size0_reg  <= size;
        px_reg     <= px;
        py_reg     <= py;
        pz_reg     <= pz;
    end

    // stage 1: scaled coordinates, res squared for the direct check
    always_ff @(posedge clk)
    begin
        sx_reg      <= 32'(px_reg * (res_reg - RES_W'(1)));
        sy_reg      <= 32'(py_reg * (res_reg - RES_W'(1)));
        sz_reg      <= 32'(pz_reg * (res_reg - RES_W'(1)));
        res2_reg    <= 12'(res_reg[5:0] * res_reg[5:0]);
        small_reg   <= (res_reg < RES_W'(64));
        res1_reg    <= res_reg;
        lvbase1_reg <= lvbase_reg;
        mask1_reg   <= mask_reg;
        size1_reg   <= size0_reg;
    end

    function automatic logic [CELL_W+CRD_W-1:0] split(input logic [31:0] s,
                                                      input logic [RES_W-1:0] r);
        logic [15:0] c;
        logic [31:0] f;
        begin
            c = s[31:16];
            if (c > r - RES_W'(2))
                c = r - RES_W'(2);
            f = s - {c, 16'd0};
            if (f > 32'(ONE_Q16))
                f = 32'(ONE_Q16);
            split = {c[CELL_W-1:0], f[CRD_W-1:0]};
        end
    endfunction

    // stage 2: cell and weight clamp, direct check
    always_comb
    begin
        logic [17:0] res3;
        res3 = 18'(res2_reg * res1_reg[5:0]);
        {lvl_next.cx, lvl_next.wx} = split(sx_reg, res1_reg);
        {lvl_next.cy, lvl_next.wy} = split(sy_reg, res1_reg);
        {lvl_next.cz, lvl_next.wz} = split(sz_reg, res1_reg);
        lvl_next.res    = res1_reg;
        lvl_next.direct = small_reg && (res3 <= 18'(size1_reg));
        lvl_next.mask   = mask1_reg;
        lvl_next.lvbase = lvbase1_reg;
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
    end

    assign lvl = lvl_reg;

endmodule

// File: rtl/core/mhg_corner.sv
// Corner pipeline: store address (direct or hashed) and trilinear weight.
// Depends on mhg_pkg. Four register stages, one corner feature per cycle.
module mhg_corner
#(
    parameter int FEATURES = mhg_pkg::FEATURES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mhg_pkg::tag_t               in_tag,
    input  mhg_pkg::lvl_t               lvl,
    input  logic [2:0]                  lv,
    output mhg_pkg::tag_t               out_tag,
    output logic [mhg_pkg::ADDR_W-1:0]  addr,
    output logic [mhg_pkg::CRD_W-1:0]   wt
);
    import mhg_pkg::*;

    tag_t        t1_reg, t2_reg, t3_reg, t4_reg;
    logic [31:0] h1_reg, h3_reg, h5_reg;
    logic [31:0] d1_reg, d2_reg, d3_reg;
    logic [15:0] z1_reg;
    logic [33:0] wab_reg;
    logic [CRD_W-1:0] wc_reg, wt2_reg, wt3_reg, wt4_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic [15:0] x, y, z;
    logic [CRD_W-1:0] wa, wb, wc;
    logic [31:0] h2, h4, h6, slot, word;
    logic [50:0] w3;

    always_comb
    begin
        x  = 16'(lvl.cx) + 16'(in_tag.corner[2]);
        y  = 16'(lvl.cy) + 16'(in_tag.corner[1]);
        z  = 16'(lvl.cz) + 16'(in_tag.corner[0]);
        wa = in_tag.corner[2] ? lvl.wx : ONE_Q16 - lvl.wx;
        wb = in_tag.corner[1] ? lvl.wy : ONE_Q16 - lvl.wy;
        wc = in_tag.corner[0] ? lvl.wz : ONE_Q16 - lvl.wz;
        h2 = h1_reg ^ (h1_reg >> 16);
        w3 = 51'(wab_reg * wc_reg) + 51'(32'h80000000);
        h4 = h3_reg ^ (h3_reg >> 13);
        h6 = h5_reg ^ (h5_reg >> 16);
        slot = lvl.direct ? d3_reg : (h6 & {16'd0, lvl.mask});
        word = 32'((slot + 32'(lvl.lvbase)) * 32'(FEATURES)) + 32'(t3_reg.feat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
        end
        else
        begin
            t1_reg <= in_tag;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: coordinate products
        h1_reg  <= 32'(32'(x) * HASH_KX) ^ 32'(32'(y) * HASH_KY)
                 ^ 32'(32'(z) * HASH_KZ) ^ 32'(32'(lv) * HASH_KL);
        d1_reg  <= 32'(32'(x) * 32'(lvl.res)) + 32'(y);
        z1_reg  <= z;
        wab_reg <= 34'(wa * wb);
        wc_reg  <= wc;
        // stage 2
        h3_reg  <= 32'(h2 * HASH_M1);
        d2_reg  <= 32'(d1_reg * 32'(lvl.res)) + 32'(z1_reg);
        wt2_reg <= w3[48:32];
        // stage 3
        h5_reg  <= 32'(h4 * HASH_M2);
        d3_reg  <= d2_reg;
        wt3_reg <= wt2_reg;
        // stage 4: word address
        addr_reg <= word[ADDR_W-1:0];
        wt4_reg  <= wt3_reg;
    end

    assign out_tag = t4_reg;
    assign addr    = addr_reg;
    assign wt      = wt4_reg;

endmodule

// File: rtl/core/mhg_store.sv
// Feature store: 65536 x 32 single-port memory with registered read.
// Depends on mhg_pkg. Carries the corner tag and weight alongside the read.
module mhg_store
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [mhg_pkg::ADDR_W-1:0]  waddr,
    input  logic [31:0]                 wdata,
    input  mhg_pkg::tag_t               rd_tag,
    input  logic [mhg_pkg::ADDR_W-1:0]  raddr,
    input  logic [mhg_pkg::CRD_W-1:0]   rd_wt,
    output mhg_pkg::tag_t               q_tag,
    output logic [31:0]                 q_data,
    output logic [mhg_pkg::CRD_W-1:0]   q_wt
);
    import mhg_pkg::*;

    logic [31:0]       mem [0:(1 << ADDR_W) - 1];
    logic [31:0]       q_data_reg;
    logic [CRD_W-1:0]  q_wt_reg;
    tag_t              q_tag_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        else
            q_data_reg <= mem[raddr];
        q_wt_reg <= rd_wt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_tag_reg <= '0;
        else
            q_tag_reg <= rd_tag;
    end

    assign q_tag  = q_tag_reg;
    assign q_data = q_data_reg;
    assign q_wt   = q_wt_reg;

endmodule

// File: rtl/core/mhg_accum.sv
// Blend accumulator: weight x feature, per-feature sums, rounding and saturation.
// Depends on mhg_pkg. Three register stages.
module mhg_accum
#(
    parameter int FEATURES = mhg_pkg::FEATURES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mhg_pkg::tag_t               in_tag,
    input  logic [31:0]                 data,
    input  logic [mhg_pkg::CRD_W-1:0]   wt,
    output logic                        res_valid,
    output logic [31:0]                 res_f0,
    output logic [31:0]                 res_f1
);
    import mhg_pkg::*;

    tag_t                      ta_reg;
    logic signed [49:0]        prod_reg;
    logic signed [ACC_W-1:0]   acc0_reg, acc1_reg;
    logic                      done_reg, res_valid_reg;
    logic [31:0]               f0_reg, f1_reg;
    logic                      done_next;

    assign done_next = ta_reg.vld && (ta_reg.corner == 3'd7)
                     && (ta_reg.feat == 1'(FEATURES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ta_reg        <= '0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ta_reg        <= in_tag;
            done_reg      <= done_next;
            res_valid_reg <= done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, wt}) * $signed(data);
        if (ta_reg.vld && !ta_reg.feat)
            acc0_reg <= (ta_reg.corner == 3'd0) ? ACC_W'(prod_reg) : acc0_reg + ACC_W'(prod_reg);
        if (ta_reg.vld && ta_reg.feat)
            acc1_reg <= (ta_reg.corner == 3'd0) ? ACC_W'(prod_reg) : acc1_reg + ACC_W'(prod_reg);
        if (done_reg)
        begin
            f0_reg <= round_sat(acc0_reg);
            f1_reg <= (FEATURES > 1) ? round_sat(acc1_reg) : 32'd0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_f0    = f0_reg;
    assign res_f1    = f1_reg;

endmodule

// File: rtl/core/multires_hash_grid_encode_top.sv
// Multiresolution hash-grid encoder. A transfer with command 0 writes one
// Q16.16 word into the 64K-word feature store. A transfer with command 1
// encodes a point and yields one result per level, level 0 first, with
// last_level marking the final one. Each level runs a setup (resolution,
// cell and weight split), then one store read per cycle for the 8 corners
// times FEATURES, then waits for the address, read, multiply, accumulate
// and rounding stages to drain. A level does not start its reads while
// the previous result still waits in the output register, so a stalled
// receiver stretches the level by the length of the stall. The single
// store port, read once per corner feature, bounds the read rate. The
// next item is taken as soon as the last level's result sits in the
// output register, even if it has not yet been taken. The store powers up
// undefined; only written entries may be read.
// Depends on mhg_pkg, mhg_level, mhg_corner, mhg_store and mhg_accum.
module multires_hash_grid_encode_top
#(
    parameter int MAX_LEVELS    = mhg_pkg::MAX_LEVELS_DEF,
    parameter int TABLE_ENTRIES = mhg_pkg::TABLE_ENTRIES_DEF,
    parameter int FEATURES      = mhg_pkg::FEATURES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data,
    // input channel
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         command,
    input  logic [16:0]  point_x,
    input  logic [16:0]  point_y,
    input  logic [16:0]  point_z,
    input  logic [14:0]  slot_address,
    input  logic         feature_select,
    input  logic [31:0]  write_value,
    // result channel
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   level_index,
    output logic [31:0]  feature_zero,
    output logic [31:0]  feature_one,
    output logic         last_level
);
    import mhg_pkg::*;

    localparam int LEVEL_LIMIT = (MAX_LEVELS < 8) ? MAX_LEVELS : 8;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_ISSUE = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [8:0]      base_reg;
    logic [3:0]      levels_reg;
    logic [3:0]      tlog_reg;
    logic [2:0]      lv_reg, lv_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [2:0]      corner_reg, corner_next;
    logic            feat_reg, feat_next;
    logic [CRD_W-1:0] px_reg, py_reg, pz_reg;

    logic            out_valid_reg;
    logic [2:0]      level_index_reg;
    logic [31:0]     feature_zero_reg, feature_one_reg;
    logic            last_level_reg;

    // effective configuration
    logic [8:0]      base_eff;
    logic [3:0]      levels_eff;
    logic [SIZE_W-1:0] size_eff, size_raw;
    logic            in_xfer, is_last_lv, issue_last, out_free;

    lvl_t            lvl;
    tag_t            issue_tag, c_tag, s_tag;
    logic [ADDR_W-1:0] c_addr, wr_addr;
    logic [CRD_W-1:0]  c_wt, s_wt;
    logic [31:0]     s_data;
    logic            res_valid;
    logic [31:0]     res_f0, res_f1;
    logic [15:0]     wr_word;

    always_comb
    begin
        base_eff = base_reg;
        if (base_reg < 9'd2)
            base_eff = 9'd2;
        else if (base_reg > 9'd256)
            base_eff = 9'd256;
        levels_eff = levels_reg;
        if (levels_reg == 4'd0)
            levels_eff = 4'd1;
        else if (levels_reg > 4'(LEVEL_LIMIT))
            levels_eff = 4'(LEVEL_LIMIT);
        size_raw = SIZE_W'(1) << tlog_reg;
        size_eff = (size_raw > SIZE_W'(TABLE_ENTRIES)) ? SIZE_W'(TABLE_ENTRIES) : size_raw;
    end

    // configuration writes, taken at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= 9'd16;
            levels_reg <= 4'd8;
            tlog_reg   <= 4'd12;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_RES: base_reg   <= cfg_data;
                REG_LEVELS:   levels_reg <= cfg_data[3:0];
                REG_TBL_LOG2: tlog_reg   <= cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign is_last_lv = ({1'b0, lv_reg} == levels_eff - 4'd1);
    assign issue_last = (corner_reg == 3'd7) && (feat_reg == 1'(FEATURES - 1));
    // a level may only start once the output register will be empty
    assign out_free   = !out_valid_reg || out_ready;

    // sequencer: levels one after another, one corner feature per cycle
    always_comb
    begin
        state_next  = state_reg;
        lv_next     = lv_reg;
        cnt_next    = cnt_reg;
        corner_next = corner_reg;
        feat_next   = feat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && command == CMD_ENCODE)
                begin
                    state_next = ST_SETUP;
                    lv_next    = 3'd0;
                    cnt_next   = 2'd0;
                end
            end
            ST_SETUP:
            begin
                if (cnt_reg != 2'd3)
                    cnt_next = cnt_reg + 2'd1;
                else if (out_free)
                begin
                    state_next  = ST_ISSUE;
                    corner_next = 3'd0;
                    feat_next   = 1'b0;
                end
            end
            ST_ISSUE:
            begin
                if (issue_last)
                    state_next = ST_DRAIN;
                else if (feat_reg == 1'(FEATURES - 1))
                begin
                    feat_next   = 1'b0;
                    corner_next = corner_reg + 3'd1;
                end
                else
                    feat_next = 1'b1;
            end
            ST_DRAIN:
            begin
                if (res_valid)
                begin
                    if (is_last_lv)
                        state_next = ST_IDLE;
                    else
                    begin
                        state_next = ST_SETUP;
                        lv_next    = lv_reg + 3'd1;
                        cnt_next   = 2'd0;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            lv_reg     <= 3'd0;
            cnt_reg    <= 2'd0;
            corner_reg <= 3'd0;
            feat_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lv_reg     <= lv_next;
            cnt_reg    <= cnt_next;
            corner_reg <= corner_next;
            feat_reg   <= feat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
            pz_reg <= point_z;
        end
    end

    always_comb
    begin
        issue_tag.vld    = (state_reg == ST_ISSUE);
        issue_tag.corner = corner_reg;
        issue_tag.feat   = feat_reg;
        // write address: slot * FEATURES + feature, wrapped to the store
        wr_word = 16'(32'(slot_address) * 32'(FEATURES))
                + 16'((32'(feature_select) < 32'(FEATURES)) ? feature_select : 1'b0);
        wr_addr = wr_word[ADDR_W-1:0];
    end

    mhg_level u_level
    (
        .clk   (clk),
        .base  (base_eff),
        .lv    (lv_reg),
        .size  (size_eff),
        .px    (px_reg),
        .py    (py_reg),
        .pz    (pz_reg),
        .lvl   (lvl)
    );

    mhg_corner #(.FEATURES(FEATURES)) u_corner
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (issue_tag),
        .lvl     (lvl),
        .lv      (lv_reg),
        .out_tag (c_tag),
        .addr    (c_addr),
        .wt      (c_wt)
    );

    mhg_store u_store
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (in_xfer && command == CMD_WRITE),
        .waddr  (wr_addr),
        .wdata  (write_value),
        .rd_tag (c_tag),
        .raddr  (c_addr),
        .rd_wt  (c_wt),
        .q_tag  (s_tag),
        .q_data (s_data),
        .q_wt   (s_wt)
    );

    mhg_accum #(.FEATURES(FEATURES)) u_accum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (s_tag),
        .data      (s_data),
        .wt        (s_wt),
        .res_valid (res_valid),
        .res_f0    (res_f0),
        .res_f1    (res_f1)
    );

    // output register; guaranteed empty when a level result lands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            level_index_reg  <= lv_reg;
            feature_zero_reg <= res_f0;
            feature_one_reg  <= res_f1;
            last_level_reg   <= is_last_lv;
        end
    end

    assign out_valid    = out_valid_reg;
    assign level_index  = level_index_reg;
    assign feature_zero = feature_zero_reg;
    assign feature_one  = feature_one_reg;
    assign last_level   = last_level_reg;

endmodule

// File: sim/multires_hash_grid_encode_top_tb.sv
// Self-checking testbench for multires_hash_grid_encode_top: fills the low feature words,
// then runs directed and random write/encode transfers under several register settings.
// Depends on mhg_pkg and the RTL under rtl/core; the predictor below is independent.
`timescale 1ns / 100ps

module multires_hash_grid_encode_top_tb;
    import mhg_pkg::*;

    localparam int  RANDOM_ITEMS = 210;
    localparam int  FILL_WORDS   = 128;   // every setting below reads only these words
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam int  DRAIN_CYCLES = 300;
    localparam int  LONG_HOLD    = 600;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [16:0] point_x;
    logic [16:0] point_y;
    logic [16:0] point_z;
    logic [14:0] slot_address;
    logic        feature_select;
    logic [31:0] write_value;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  level_index;
    logic [31:0] feature_zero;
    logic [31:0] feature_one;
    logic        last_level;

    // one level result as it should appear on the result channel
    typedef struct {
        logic [2:0]  lvl;
        logic [31:0] f0;
        logic [31:0] f1;
        logic        last;
    } level_result_t;

    // one row of the directed table; known marks a level-0 result read off by hand
    typedef struct {
        logic        cmd;
        logic [16:0] px;
        logic [16:0] py;
        logic [16:0] pz;
        logic [14:0] slot;
        logic        fsel;
        logic [31:0] val;
        logic        known;
        logic [31:0] k0;
        logic [31:0] k1;
    } stim_row_t;

    level_result_t pending_levels[$];
    logic [31:0]   store_copy[65536];
    logic [8:0]    base_res_q;
    logic [3:0]    levels_q;
    logic [3:0]    tbl_log2_q;

    int     mismatches;
    longint cycle_count;
    int     tx_idle_pct;
    int     rx_stall_pct;
    logic   hold_request;
    int     hold_left;

    multires_hash_grid_encode_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .slot_address   (slot_address),
        .feature_select (feature_select),
        .write_value    (write_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .level_index    (level_index),
        .feature_zero   (feature_zero),
        .feature_one    (feature_one),
        .last_level     (last_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog: a hung handshake must not run forever
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multires_hash_grid_encode_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // avalanche hash of a corner and its level
    function automatic logic [31:0] corner_hash(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic [31:0] lv);
        logic [31:0] h;
        h = (x * 32'h8da6b343) ^ (y * 32'hd8163841) ^ (z * 32'hcb1ab31f);
        h = h ^ (lv * 32'h1234567f);
        h = h ^ (h >> 16);
        h = h * 32'h85ebca6b;
        h = h ^ (h >> 13);
        h = h * 32'hc2b2ae35;
        h = h ^ (h >> 16);
        return h;
    endfunction

    // coordinate to cell index and Q0.16 fraction, both clamped
    function automatic void axis_cell(input logic [16:0] p, input longint unsigned res,
                                      output longint unsigned cell_idx,
                                      output longint unsigned frac);
        longint unsigned s;
        s        = longint'(p) * (res - 1);
        cell_idx = s >> 16;
        if (cell_idx > res - 2)
            cell_idx = res - 2;
        frac = s - (cell_idx << 16);
        if (frac > 65536)
            frac = 65536;
    endfunction

    // Q16.32 sum to Q16.16, round half up, saturate
    function automatic logic [31:0] to_q16_sat(longint acc);
        longint r;
        r = (acc + 32768) >>> 16;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // queue the per-level blends of one point under the current settings
    function automatic void blend_point(logic [16:0] px, logic [16:0] py, logic [16:0] pz);
        longint unsigned base, levels, size, mask, res, slot, wt;
        longint unsigned cx, cy, cz, wx, wy, wz, wa, wb, wc, x, y, z;
        longint acc0, acc1;
        logic [15:0] addr;
        level_result_t r;
        base = (base_res_q < 2) ? 2 : base_res_q;
        if (base > 256)
            base = 256;
        levels = (levels_q < 1) ? 1 : levels_q;
        if (levels > 8)
            levels = 8;
        size = 64'd1 << tbl_log2_q;
        if (size > 4096)
            size = 4096;
        mask = size - 1;
        for (int lv = 0; lv < levels; lv++)
        begin
            res = base << lv;
            axis_cell(px, res, cx, wx);
            axis_cell(py, res, cy, wy);
            axis_cell(pz, res, cz, wz);
            acc0 = 0;
            acc1 = 0;
            for (int c = 0; c < 8; c++)
            begin
                x  = cx + c[2];
                y  = cy + c[1];
                z  = cz + c[0];
                wa = c[2] ? wx : 65536 - wx;
                wb = c[1] ? wy : 65536 - wy;
                wc = c[0] ? wz : 65536 - wz;
                wt = (wa * wb * wc + 64'h8000_0000) >> 32;
                if (res * res * res <= size)
                    slot = (x * res + y) * res + z;
                else
                    slot = corner_hash(x[31:0], y[31:0], z[31:0], lv) & mask;
                slot = slot + lv * size;
                addr = 16'(slot * 2);
                acc0 += longint'(wt) * longint'($signed(store_copy[addr]));
                addr = 16'(slot * 2 + 1);
                acc1 += longint'(wt) * longint'($signed(store_copy[addr]));
            end
            r.lvl  = 3'(lv);
            r.f0   = to_q16_sat(acc0);
            r.f1   = to_q16_sat(acc1);
            r.last = (lv + 1 == levels);
            pending_levels.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, long hold on request, field checks
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_levels.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result: level %0d f0 %h f1 %h last %b",
                                 level_index, feature_zero, feature_one, last_level);
                end
                else
                begin
                    level_result_t e;
                    e = pending_levels.pop_front();
                    if (e.lvl !== level_index || e.f0 !== feature_zero ||
                        e.f1 !== feature_one || e.last !== last_level)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp lvl %0d f0 %h f1 %h last %b, got lvl %0d f0 %h f1 %h last %b",
                                     e.lvl, e.f0, e.f1, e.last,
                                     level_index, feature_zero, feature_one, last_level);
                    end
                end
            end
            // long hold: counted here so the sender keeps pushing into a full pipe
            if (hold_request && hold_left == 0)
            begin
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= (hold_left == 1);
            end
            else
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // offer one transfer, wait for acceptance, then update the prediction
    task automatic send_item(logic cmd, logic [16:0] px, logic [16:0] py, logic [16:0] pz,
                             logic [14:0] slot, logic fsel, logic [31:0] val);
        in_valid       <= 1'b1;
        command        <= cmd;
        point_x        <= px;
        point_y        <= py;
        point_z        <= pz;
        slot_address   <= slot;
        feature_select <= fsel;
        write_value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        if (cmd == CMD_WRITE)
            store_copy[{slot, fsel}] = val;
        else
            blend_point(px, py, pz);
    endtask

    // random gap before the next transfer, or none
    task automatic maybe_idle();
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // drained: every result in, plus slack for a trailing write in flight
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_BASE_RES: base_res_q = val;
            REG_LEVELS:   levels_q   = val[3:0];
            REG_TBL_LOG2: tbl_log2_q = val[3:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // coordinates biased towards the edges, including beyond one
    function automatic logic [16:0] pick_coord();
        case ($urandom_range(7))
            0: return 17'd0;
            1: return ONE_Q16;
            2: return 17'($urandom);
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    // write slots mostly inside the filled region
    function automatic logic [14:0] pick_slot();
        if ($urandom_range(3) != 0)
            return 15'($urandom_range(FILL_WORDS / 2 - 1));
        return 15'($urandom);
    endfunction

    stim_row_t directed[$];

    initial
    begin
        int per_phase;
        stim_row_t row;
        logic [8:0] phase_base[6];
        logic [3:0] phase_lvls[6];
        logic [3:0] phase_log2[6];
        int phase_idle[6];
        int phase_stall[6];

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_BASE_RES;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = CMD_WRITE;
        point_x        = '0;
        point_y        = '0;
        point_z        = '0;
        slot_address   = '0;
        feature_select = 1'b0;
        write_value    = '0;
        hold_request   = 1'b0;
        mismatches     = 0;
        cycle_count    = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        base_res_q     = 9'd16;
        levels_q       = 4'd8;
        tbl_log2_q     = 4'd12;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the low words; every setting used below reads nothing else
        for (int a = 0; a < FILL_WORDS; a++)
            send_item(CMD_WRITE, '0, '0, '0, 15'(a >> 1), a[0], $urandom);
        drain();

        // directed part: base 2, 8 levels, 8-entry tables.
        // Level 0 is direct-indexed (2^3 = 8), so the origin reads slot 0 alone
        // and a point at or beyond one reads slot 7 alone.
        write_reg(REG_BASE_RES, 9'd2);
        write_reg(REG_LEVELS, 9'd8);
        write_reg(REG_TBL_LOG2, 9'd3);
        directed.push_back('{CMD_WRITE, 0, 0, 0, 15'd0, 1'b0, 32'h7fffffff, 0, 0, 0});
        directed.push_back('{CMD_WRITE, 0, 0, 0, 15'd0, 1'b1, 32'h80000000, 0, 0, 0});
        directed.push_back('{CMD_ENCODE, 0, 0, 0, 0, 0, 0, 1, 32'h7fffffff, 32'h80000000});
        directed.push_back('{CMD_WRITE, 0, 0, 0, 15'd7, 1'b0, 32'h00012345, 0, 0, 0});
        directed.push_back('{CMD_WRITE, 0, 0, 0, 15'd7, 1'b1, 32'hfffe0000, 0, 0, 0});
        directed.push_back('{CMD_ENCODE, ONE_Q16, ONE_Q16, ONE_Q16, 0, 0, 0, 1,
                             32'h00012345, 32'hfffe0000});
        // beyond one clamps to the same top cell
        directed.push_back('{CMD_ENCODE, 17'h1ffff, 17'h1ffff, 17'h1ffff, 0, 0, 0, 1,
                             32'h00012345, 32'hfffe0000});
        directed.push_back('{CMD_ENCODE, 17'd32768, 17'd32768, 17'd32768, 0, 0, 0, 0, 0, 0});
        directed.push_back('{CMD_ENCODE, 0, ONE_Q16, 17'd1, 0, 0, 0, 0, 0, 0});
        directed.push_back('{CMD_ENCODE, 17'd65535, 0, 17'h10000, 0, 0, 0, 0, 0, 0});
        // top slot address, both feature selects, extreme values
        directed.push_back('{CMD_WRITE, 0, 0, 0, 15'h7fff, 1'b1, 32'h7fffffff, 0, 0, 0});
        directed.push_back('{CMD_WRITE, 0, 0, 0, 15'h7fff, 1'b0, 32'h80000000, 0, 0, 0});
        directed.push_back('{CMD_ENCODE, 17'd4097, 17'd60000, 17'd12345, 0, 0, 0, 0, 0, 0});
        for (int i = 0; i < directed.size(); i++)
        begin
            row = directed[i];
            send_item(row.cmd, row.px, row.py, row.pz, row.slot, row.fsel, row.val);
            // hand-read level 0 replaces the predicted one
            if (row.known)
            begin
                pending_levels[pending_levels.size() - 8].f0 = row.k0;
                pending_levels[pending_levels.size() - 8].f1 = row.k1;
            end
        end
        drain();

        // phases: register extremes and out-of-range codes, with each idling mode;
        // every setting keeps its reads inside the filled words
        phase_base  = '{9'd0,  9'd511, 9'd2, 9'd256, 9'd5, 9'd16};
        phase_lvls  = '{4'd0,  4'd15,  4'd8, 4'd8,   4'd3, 4'd8};
        phase_log2  = '{4'd15, 4'd0,   4'd3, 4'd2,   4'd3, 4'd3};
        phase_idle  = '{0, 52, 0, 17, 52, 0};
        phase_stall = '{0, 0, 52, 17, 17, 0};
        per_phase   = RANDOM_ITEMS / 6;

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_BASE_RES, phase_base[ph]);
            write_reg(REG_LEVELS, {5'd0, phase_lvls[ph]});
            write_reg(REG_TBL_LOG2, {5'd0, phase_log2[ph]});
            tx_idle_pct  = phase_idle[ph];
            rx_stall_pct = phase_stall[ph];
            for (int n = 0; n < per_phase; n++)
            begin
                // one long receiver hold mid-run while items keep coming
                hold_request <= (ph == 5 && n == 10);
                // once, the sender waits for the pipe to empty
                if (ph == 3 && n == per_phase / 2 && pending_levels.size() != 0)
                begin
                    in_valid <= 1'b0;
                    while (pending_levels.size() != 0)
                        @(posedge clk);
                end
                if ($urandom_range(9) < 7)
                    send_item(CMD_ENCODE, pick_coord(), pick_coord(), pick_coord(),
                              15'($urandom), 1'($urandom), $urandom);
                else
                    send_item(CMD_WRITE, pick_coord(), pick_coord(), pick_coord(),
                              pick_slot(), 1'($urandom), $urandom);
                maybe_idle();
            end
            hold_request <= 1'b0;
            drain();
        end

        if (mismatches == 0 && pending_levels.size() == 0)
            $display("multires_hash_grid_encode_top test passed");
        else
            $display("multires_hash_grid_encode_top test failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mhg_pkg.sv
rtl/core/mhg_level.sv
rtl/core/mhg_corner.sv
rtl/core/mhg_store.sv
rtl/core/mhg_accum.sv
rtl/core/multires_hash_grid_encode_top.sv
sim/multires_hash_grid_encode_top_tb.sv
